// File: rtl/core/eqsb_pkg.sv
// shared types and constants for the error queue and status byte block
package eqsb_pkg;

   localparam int unsigned DEPTH = 16;
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CODE_W = 6;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LOW_W = 3;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   localparam logic [CODE_W-1:0] OVERFLOW_RESET = 6'd38;

   localparam logic [BYTE_W-1:0] LOW_MASK = 8'h07;
   localparam logic [BYTE_W-1:0] MSS_MASK = 8'hBF;
   localparam logic [BYTE_W-1:0] MSS_BIT = 8'h40;
   localparam logic [BYTE_W-1:0] ESB_BIT = 8'h20;
   localparam logic [BYTE_W-1:0] MAV_BIT = 8'h10;

   typedef enum logic [1:0] {
      CMD_SAVE = 2'd0,
      CMD_READ = 2'd1,
      CMD_RESET = 2'd2,
      CMD_REFRESH = 2'd3
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SERVICE_ENABLE = 2'd0,
      CSR_EVENT_ENABLE = 2'd1,
      CSR_OVERFLOW_CODE = 2'd2,
      CSR_UNUSED = 2'd3
   } csr_index_type;

   // queue outcome handed to the status stage
   typedef struct packed {
      logic [CODE_W-1:0] popped;
      logic not_empty;
   } queue_result_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_LAST) begin
         n = '0;
      end else begin
         n = p + PTR_W'(1);
      end
      return n;
   endfunction

endpackage

// File: rtl/core/eqsb_queue.sv
// code ring with write and read pointers; one command per cycle
module eqsb_queue (
   input  logic clock,
   input  logic reset,
   input  logic valid,
   input  eqsb_pkg::command_type command,
   input  logic [eqsb_pkg::CODE_W-1:0] error_code,
   input  logic [eqsb_pkg::CODE_W-1:0] overflow_code,
   output eqsb_pkg::queue_result_type result
);
   import eqsb_pkg::*;

   logic [CODE_W-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_next, rd_next;
   logic store_we;
   logic [PTR_W-1:0] store_addr;
   logic [CODE_W-1:0] store_data;
   logic not_empty;

   assign wr_next = ring_next(wr_ptr_ff);
   assign rd_next = ring_next(rd_ptr_ff);
   assign not_empty = (wr_ptr_ff != rd_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      store_we = 1'b0;
      store_addr = wr_next;
      store_data = error_code;
      result.popped = '0;
      if (valid) begin
         case (command)
            CMD_SAVE: begin
               store_we = 1'b1;
               if (wr_next != rd_ptr_ff) begin
                  wr_ptr_in = wr_next;
               end else begin
                  // full: newest entry takes the overflow code
                  store_addr = wr_ptr_ff;
                  store_data = overflow_code;
               end
            end
            CMD_READ: begin
               if (not_empty) begin
                  rd_ptr_in = rd_next;
                  result.popped = store_ff[rd_next];
               end
            end
            CMD_RESET: begin
               wr_ptr_in = '0;
               rd_ptr_in = '0;
            end
            default: begin
            end
         endcase
      end
      result.not_empty = (wr_ptr_in != rd_ptr_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_addr] <= store_data;
      end
   end

endmodule

// File: rtl/core/eqsb_status.sv
// status byte assembly and result register
module eqsb_status (
   input  logic clock,
   input  logic reset,
   input  logic valid,
   input  eqsb_pkg::queue_result_type queue_result,
   input  logic [eqsb_pkg::BYTE_W-1:0] event_status,
   input  logic [eqsb_pkg::LOW_W-1:0] low_status,
   input  logic [eqsb_pkg::BYTE_W-1:0] service_enable,
   input  logic [eqsb_pkg::BYTE_W-1:0] event_enable,
   output logic strobe,
   output logic [eqsb_pkg::CODE_W-1:0] read_code,
   output logic [eqsb_pkg::BYTE_W-1:0] status_byte
);
   import eqsb_pkg::*;

   logic strobe_ff;
   logic [CODE_W-1:0] code_ff;
   logic [BYTE_W-1:0] status_ff, status_in;
   logic [BYTE_W-1:0] summary;

   always_comb begin
      summary = {{(BYTE_W-LOW_W){1'b0}}, low_status} & LOW_MASK;
      if ((event_status & event_enable) != '0) begin
         summary = summary | ESB_BIT;
      end
      if (queue_result.not_empty) begin
         summary = summary | MAV_BIT;
      end
      status_in = summary;
      // master summary taken over all the other bits
      if ((summary & service_enable & MSS_MASK) != '0) begin
         status_in = summary | MSS_BIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid;
      end
   end

   always_ff @(posedge clock) begin
      if (valid) begin
         code_ff <= queue_result.popped;
         status_ff <= status_in;
      end
   end

   assign strobe = strobe_ff;
   assign read_code = code_ff;
   assign status_byte = status_ff;

endmodule

// File: rtl/core/error_queue_status_byte.sv
// top level: request register, error queue and status byte result stage
//
// Takes one command every clock cycle; busy is never raised. Each command
// gives exactly one result beat on rsp_strobe after it is taken: it is held in
// the request register, then goes through the queue update and status byte
// logic into the result register. The queue keeps at most DEPTH-1 codes in a
// register ring with one write and one read port. Results are shown for a
// single cycle and cannot be held off, so the receiver must take every beat.
// Configuration writes take effect at the edge they are written.
module error_queue_status_byte (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_command,
   input  logic [eqsb_pkg::CODE_W-1:0] req_error_code,
   input  logic [eqsb_pkg::BYTE_W-1:0] req_event_status,
   input  logic [eqsb_pkg::LOW_W-1:0] req_low_status,
   output logic rsp_strobe,
   output logic [eqsb_pkg::CODE_W-1:0] rsp_read_code,
   output logic [eqsb_pkg::BYTE_W-1:0] rsp_status_byte,
   input  logic csr_write_enable,
   input  logic [eqsb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [eqsb_pkg::BYTE_W-1:0] csr_write_data
);
   import eqsb_pkg::*;

   logic req_valid_ff;
   command_type command_ff;
   logic [CODE_W-1:0] error_code_ff;
   logic [BYTE_W-1:0] event_status_ff;
   logic [LOW_W-1:0] low_status_ff;

   logic [BYTE_W-1:0] service_enable_ff;
   logic [BYTE_W-1:0] event_enable_ff;
   logic [CODE_W-1:0] overflow_code_ff;

   logic accept;
   queue_result_type queue_result;

   assign busy = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         command_ff <= command_type'(req_command);
         error_code_ff <= req_error_code;
         event_status_ff <= req_event_status;
         low_status_ff <= req_low_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         service_enable_ff <= '0;
         event_enable_ff <= '0;
         overflow_code_ff <= OVERFLOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SERVICE_ENABLE: service_enable_ff <= csr_write_data;
            CSR_EVENT_ENABLE: event_enable_ff <= csr_write_data;
            CSR_OVERFLOW_CODE: overflow_code_ff <= csr_write_data[CODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   eqsb_queue u_queue (
      .clock(clock),
      .reset(reset),
      .valid(req_valid_ff),
      .command(command_ff),
      .error_code(error_code_ff),
      .overflow_code(overflow_code_ff),
      .result(queue_result)
   );

   eqsb_status u_status (
      .clock(clock),
      .reset(reset),
      .valid(req_valid_ff),
      .queue_result(queue_result),
      .event_status(event_status_ff),
      .low_status(low_status_ff),
      .service_enable(service_enable_ff),
      .event_enable(event_enable_ff),
      .strobe(rsp_strobe),
      .read_code(rsp_read_code),
      .status_byte(rsp_status_byte)
   );

endmodule

// File: tb/sv/error_queue_status_byte_checker.sv
// reply checker for the error queue: tracks the ring, predicts each reply and compares
module error_queue_status_byte_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic [1:0] req_command,
   input  logic [eqsb_pkg::CODE_W-1:0] req_error_code,
   input  logic [eqsb_pkg::BYTE_W-1:0] req_event_status,
   input  logic [eqsb_pkg::LOW_W-1:0] req_low_status,
   input  logic rsp_strobe,
   input  logic [eqsb_pkg::CODE_W-1:0] rsp_read_code,
   input  logic [eqsb_pkg::BYTE_W-1:0] rsp_status_byte,
   input  logic csr_write_enable,
   input  logic [eqsb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [eqsb_pkg::BYTE_W-1:0] csr_write_data,
   output int mismatch_count,
   output int replies_owed
);
   import eqsb_pkg::*;

   typedef struct packed {
      logic [CODE_W-1:0] read_code;
      logic [BYTE_W-1:0] status_byte;
   } queue_reply_type;

   logic [CODE_W-1:0] code_ring [DEPTH];
   logic [PTR_W-1:0] newest_slot;
   logic [PTR_W-1:0] before_oldest;
   logic [BYTE_W-1:0] service_mask;
   logic [BYTE_W-1:0] event_mask;
   logic [CODE_W-1:0] overflow_fill;
   queue_reply_type owed_replies [$];
   queue_reply_type wanted;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] slot);
      if (slot == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return slot + PTR_W'(1);
   endfunction

   // updates the tracked ring for one command and returns the reply it should give
   function automatic queue_reply_type apply_command(input command_type cmd,
                                                     input logic [CODE_W-1:0] code,
                                                     input logic [BYTE_W-1:0] events,
                                                     input logic [LOW_W-1:0] low);
      queue_reply_type reply;
      reply.read_code = '0;
      case (cmd)
         CMD_SAVE: begin
            if (advance(newest_slot) != before_oldest) begin
               newest_slot = advance(newest_slot);
               code_ring[newest_slot] = code;
            end else begin
               // full ring: newest entry is overwritten
               code_ring[newest_slot] = overflow_fill;
            end
         end
         CMD_READ: begin
            if (newest_slot != before_oldest) begin
               before_oldest = advance(before_oldest);
               reply.read_code = code_ring[before_oldest];
            end
         end
         CMD_RESET: begin
            newest_slot = '0;
            before_oldest = '0;
         end
         default: begin
         end
      endcase
      reply.status_byte = BYTE_W'(low) & LOW_MASK;
      if ((events & event_mask) != '0) begin
         reply.status_byte |= ESB_BIT;
      end
      if (newest_slot != before_oldest) begin
         reply.status_byte |= MAV_BIT;
      end
      // summary bit taken last, from all other bits
      if ((reply.status_byte & service_mask & MSS_MASK) != '0) begin
         reply.status_byte |= MSS_BIT;
      end
      return reply;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         newest_slot = '0;
         before_oldest = '0;
         service_mask = '0;
         event_mask = '0;
         overflow_fill = OVERFLOW_RESET;
         owed_replies.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_SERVICE_ENABLE: service_mask = csr_write_data;
               CSR_EVENT_ENABLE: event_mask = csr_write_data;
               CSR_OVERFLOW_CODE: overflow_fill = csr_write_data[CODE_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_strobe) begin
            if (owed_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected reply beat: read_code %0d status_byte %02h",
                           rsp_read_code, rsp_status_byte);
               end
            end else begin
               wanted = owed_replies.pop_front();
               if (rsp_read_code !== wanted.read_code ||
                   rsp_status_byte !== wanted.status_byte) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display({"reply mismatch: read_code exp %0d got %0d, ",
                               "status_byte exp %02h got %02h"},
                              wanted.read_code, rsp_read_code,
                              wanted.status_byte, rsp_status_byte);
                  end
               end
            end
         end
         if (start && !busy) begin
            owed_replies.push_back(apply_command(command_type'(req_command), req_error_code,
                                                 req_event_status, req_low_status));
         end
      end
      replies_owed = owed_replies.size();
   end

endmodule

// File: tb/sv/error_queue_status_byte_test.sv
// top of the error queue testbench: clock, reset, commands, settings and verdict
module error_queue_status_byte_test;
   import eqsb_pkg::*;

   localparam int ITEM_TARGET = 1700;
   localparam int RANDOM_PHASES = 6;
   localparam int STALL_LIMIT = 2000;

   typedef enum int {
      FILL_TRAFFIC,
      DRAIN_TRAFFIC,
      MIXED_TRAFFIC
   } traffic_mode_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [1:0] req_command;
   logic [CODE_W-1:0] req_error_code;
   logic [BYTE_W-1:0] req_event_status;
   logic [LOW_W-1:0] req_low_status;
   logic rsp_strobe;
   logic [CODE_W-1:0] rsp_read_code;
   logic [BYTE_W-1:0] rsp_status_byte;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0] csr_write_data;
   int mismatch_count;
   int replies_owed;
   int quiet_cycles = 0;

   error_queue_status_byte u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_error_code(req_error_code),
      .req_event_status(req_event_status),
      .req_low_status(req_low_status),
      .rsp_strobe(rsp_strobe),
      .rsp_read_code(rsp_read_code),
      .rsp_status_byte(rsp_status_byte),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   error_queue_status_byte_checker u_replies (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_error_code(req_error_code),
      .req_event_status(req_event_status),
      .req_low_status(req_low_status),
      .rsp_strobe(rsp_strobe),
      .rsp_read_code(rsp_read_code),
      .rsp_status_byte(rsp_status_byte),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count),
      .replies_owed(replies_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ends the run when neither a command nor a reply moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // offers one command and returns at the edge that takes it
   task automatic send_command(input command_type cmd, input logic [CODE_W-1:0] code,
                               input logic [BYTE_W-1:0] events,
                               input logic [LOW_W-1:0] low);
      start <= 1'b1;
      req_command <= cmd;
      req_error_code <= code;
      req_event_status <= events;
      req_low_status <= low;
      do @(negedge clock); while (busy);
      @(posedge clock);
   endtask

   // idle cycles with junk on the request fields
   task automatic idle_for(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         req_command <= 2'($urandom);
         req_error_code <= CODE_W'($urandom);
         req_event_status <= BYTE_W'($urandom);
         req_low_status <= LOW_W'($urandom);
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(3, 1);
      end else if (roll < 97) begin
         return $urandom_range(12, 4);
      end
      return $urandom_range(40, 20);
   endfunction

   // lets every owed reply arrive before anything else happens
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (replies_owed != 0);
      @(posedge clock);
   endtask

   task automatic program_settings(input logic [BYTE_W-1:0] service,
                                   input logic [BYTE_W-1:0] events,
                                   input logic [BYTE_W-1:0] overflow,
                                   input logic [BYTE_W-1:0] spare);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SERVICE_ENABLE;
      csr_write_data <= service;
      @(posedge clock);
      csr_index <= CSR_EVENT_ENABLE;
      csr_write_data <= events;
      @(posedge clock);
      csr_index <= CSR_OVERFLOW_CODE;
      csr_write_data <= overflow;
      @(posedge clock);
      // unused index must be ignored
      csr_index <= CSR_UNUSED;
      csr_write_data <= spare;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic command_type pick_command(input traffic_mode_type mode);
      int roll;
      roll = $urandom_range(99);
      case (mode)
         FILL_TRAFFIC: begin
            if (roll < 78) return CMD_SAVE;
            if (roll < 90) return CMD_READ;
            if (roll < 99) return CMD_REFRESH;
            return CMD_RESET;
         end
         DRAIN_TRAFFIC: begin
            if (roll < 72) return CMD_READ;
            if (roll < 90) return CMD_SAVE;
            if (roll < 98) return CMD_REFRESH;
            return CMD_RESET;
         end
         default: begin
            if (roll < 40) return CMD_SAVE;
            if (roll < 80) return CMD_READ;
            if (roll < 95) return CMD_REFRESH;
            return CMD_RESET;
         end
      endcase
   endfunction

   // bursts of fill, drain or mixed traffic so the ring reaches both full and empty
   task automatic run_random(input int count);
      int sent;
      int burst_left;
      int roll;
      bit no_gaps;
      traffic_mode_type mode;
      logic [CODE_W-1:0] code;
      logic [BYTE_W-1:0] events;
      sent = 0;
      burst_left = 0;
      no_gaps = 1'b0;
      mode = MIXED_TRAFFIC;
      while (sent < count) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(60, 8);
            mode = traffic_mode_type'($urandom_range(2));
            no_gaps = ($urandom_range(3) == 0);
         end
         roll = $urandom_range(9);
         if (roll == 0) begin
            code = '0;
         end else if (roll == 1) begin
            code = '1;
         end else begin
            code = CODE_W'($urandom);
         end
         events = ($urandom_range(4) == 0) ? '0 : BYTE_W'($urandom);
         send_command(pick_command(mode), code, events, LOW_W'($urandom));
         sent++;
         burst_left--;
         if (!no_gaps) begin
            idle_for(pick_gap());
         end
      end
   endtask

   initial begin
      int k;
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_REFRESH;
      req_error_code <= '0;
      req_event_status <= '0;
      req_low_status <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_SERVICE_ENABLE;
      csr_write_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_settings(8'hFF, 8'hFF, 8'h15, 8'hFF);
      // read of the empty ring, then status extremes
      send_command(CMD_READ, 6'd63, 8'h00, 3'd0);
      send_command(CMD_REFRESH, 6'd0, 8'hFF, 3'd7);
      send_command(CMD_SAVE, 6'd0, 8'h01, 3'd0);
      send_command(CMD_SAVE, 6'd63, 8'h80, 3'd7);
      idle_for(2);
      send_command(CMD_READ, 6'd0, 8'h00, 3'd5);
      send_command(CMD_READ, 6'd0, 8'h00, 3'd2);
      // fill the ring, then one save past full
      for (k = 0; k < DEPTH - 1; k++) begin
         send_command(CMD_SAVE, CODE_W'(k * 4 + 1), BYTE_W'(1 << (k % 8)), LOW_W'(k));
      end
      send_command(CMD_SAVE, 6'd2, 8'h00, 3'd0);
      send_command(CMD_READ, 6'd0, 8'h00, 3'd0);
      send_command(CMD_RESET, 6'd0, 8'hFF, 3'd7);
      send_command(CMD_READ, 6'd0, 8'h00, 3'd0);
      drain();

      for (k = 0; k < RANDOM_PHASES; k++) begin
         case (k)
            0: program_settings(8'h00, 8'h00, 8'h00, 8'h00);
            1: program_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF);
            2: program_settings(8'h10, 8'hAA, 8'h26, 8'h01);
            3: program_settings(8'h40, 8'h55, 8'h01, 8'h00);
            default: program_settings(BYTE_W'($urandom), BYTE_W'($urandom),
                                      BYTE_W'($urandom), BYTE_W'($urandom));
         endcase
         run_random(ITEM_TARGET / RANDOM_PHASES);
         drain();
      end

      repeat (4) @(posedge clock);
      if (replies_owed != 0) begin
         $display("%0d replies never arrived", replies_owed);
      end
      if (mismatch_count == 0 && replies_owed == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
